// File: sv/hdm_pkg.sv
// Shared types, constants and popcount helpers for the Hamming descriptor matcher.
// Used by hdm_ctrl, hdm_dp and hamming_nearest_descriptor_match_top.
package hdm_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned IN_WORDS   = 4;
  localparam int unsigned QIDX_W     = 16;
  localparam int unsigned OUT_IDX_W  = 10;
  localparam int unsigned OUT_DIST_W = 9;
  localparam int unsigned PC_W       = 7;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic clear;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic pipe_empty;
    logic out_free;
  } sts_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  function automatic logic [PC_W-1:0] popcnt64(input logic [WORD_W-1:0] x);
    logic [PC_W-1:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + PC_W'(popcnt8(x[k*8 +: 8]));
    end
    return n;
  endfunction

endpackage

// File: sv/hamming_nearest_descriptor_match_top.sv
// Hamming nearest-descriptor matcher top level; depends on hdm_pkg, hdm_ctrl and hdm_dp.
// Append and clear act on the transfer itself. A query reads the N stored train rows, N being
// the stored count, one row per cycle (no row on an empty store), then two pipeline stages
// drain and the result is loaded into the output register. One item is in work at a time, so a
// query holds the input off until its result is loaded, and longer while an earlier result
// waits unread. Reset empties the store; memory is not cleared.
module hamming_nearest_descriptor_match_top
  import hdm_pkg::*;
#(
  parameter int unsigned MAX_TRAIN  = 1024,
  parameter int unsigned DESC_WORDS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // query_index [15:0], desc_word_0 [79:16], desc_word_1 [143:80],
  // desc_word_2 [207:144], desc_word_3 [271:208]
  input  logic [271:0] s_axis_tdata,
  // mode [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // match_query_index [15:0], best_train_index [25:16], best_distance [34:26],
  // zero [39:35]
  output logic [39:0]  m_axis_tdata,
  // found [0]
  output logic         m_axis_tuser
);

  cmd_t                            cmd;
  sts_t                            sts;
  logic [IN_WORDS-1:0][WORD_W-1:0] desc;
  logic [QIDX_W-1:0]               m_qidx;
  logic [OUT_IDX_W-1:0]            m_idx;
  logic [OUT_DIST_W-1:0]           m_dist;

  for (genvar w = 0; w < IN_WORDS; w++) begin : g_desc
    assign desc[w] = s_axis_tdata[QIDX_W + w*WORD_W +: WORD_W];
  end

  hdm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .mode_i    (mode_e'(s_axis_tuser)),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  hdm_dp #(
    .MAX_TRAIN  (MAX_TRAIN),
    .DESC_WORDS (DESC_WORDS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .qidx_i    (s_axis_tdata[QIDX_W-1:0]),
    .desc_i    (desc),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_found_o (m_axis_tuser),
    .m_qidx_o  (m_qidx),
    .m_idx_o   (m_idx),
    .m_dist_o  (m_dist)
  );

  assign m_axis_tdata = {5'b0, m_dist, m_idx, m_qidx};

endmodule

// File: sv/hdm_ctrl.sv
// Controller state machine of the descriptor matcher: sequences append, clear and
// the query scan. Depends on hdm_pkg for the command and status structs.
module hdm_ctrl
  import hdm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  mode_e mode_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign s_ready_o = (state_q == ST_IDLE);
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (mode_i)
            MODE_APPEND: cmd_o.append = !sts_i.full;
            MODE_CLEAR:  cmd_o.clear  = 1'b1;
            MODE_QUERY: begin
              cmd_o.start = 1'b1;
              state_d     = sts_i.empty ? ST_DRAIN : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The result moves out once the compare pipeline is empty and the
        // output register can take it.
        if (sts_i.pipe_empty && sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/hdm_dp.sv
// Datapath of the descriptor matcher: train memory, fill count, scan address,
// XOR/popcount pipeline, best-match tracking and output register. Uses hdm_pkg.
module hdm_dp
  import hdm_pkg::*;
#(
  parameter int unsigned MAX_TRAIN  = 1024,
  parameter int unsigned DESC_WORDS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmd_t                              cmd_i,
  output sts_t                              sts_o,
  input  logic [QIDX_W-1:0]                 qidx_i,
  input  logic [IN_WORDS-1:0][WORD_W-1:0]   desc_i,
  input  logic                              m_ready_i,
  output logic                              m_valid_o,
  output logic                              m_found_o,
  output logic [QIDX_W-1:0]                 m_qidx_o,
  output logic [OUT_IDX_W-1:0]              m_idx_o,
  output logic [OUT_DIST_W-1:0]             m_dist_o
);

  localparam int unsigned AW    = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
  localparam int unsigned CW    = $clog2(MAX_TRAIN + 1);
  localparam int unsigned DISTW = $clog2(WORD_W * DESC_WORDS + 1);

  typedef logic [DESC_WORDS-1:0][WORD_W-1:0] row_t;

  row_t                  mem [MAX_TRAIN];
  row_t                  desc_row;
  row_t                  qry_q;
  row_t                  rd_data_q;
  logic [QIDX_W-1:0]     qidx_q;
  logic [CW-1:0]         count_q;
  logic [AW-1:0]         addr_q;
  logic                  rd_v_q;
  logic [AW-1:0]         rd_idx_q;
  logic [DESC_WORDS-1:0][PC_W-1:0] pc_q;
  logic                  pc_v_q;
  logic [AW-1:0]         pc_idx_q;
  logic [DISTW-1:0]      sum;
  logic                  have_q;
  logic [AW-1:0]         best_idx_q;
  logic [DISTW-1:0]      best_dist_q;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [QIDX_W-1:0]     out_qidx_q;
  logic [OUT_IDX_W-1:0]  out_idx_q;
  logic [OUT_DIST_W-1:0] out_dist_q;
  logic                  full;

  // Words of the descriptor beyond the input words are zero.
  for (genvar w = 0; w < DESC_WORDS; w++) begin : g_row
    if (w < IN_WORDS) begin : g_in
      assign desc_row[w] = desc_i[w];
    end else begin : g_zero
      assign desc_row[w] = '0;
    end
  end

  assign full = (count_q == CW'(MAX_TRAIN));

  always_comb begin
    sts_o            = '0;
    sts_o.full       = full;
    sts_o.empty      = (count_q == '0);
    sts_o.scan_last  = ((CW'(addr_q) + CW'(1)) == count_q);
    sts_o.pipe_empty = !rd_v_q && !pc_v_q;
    sts_o.out_free   = !out_valid_q || m_ready_i;
  end

  // Train memory: one descriptor row per entry, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[count_q[AW-1:0]] <= desc_row;
    end
    if (cmd_i.step) begin
      rd_data_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.append && !full) begin
      count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qry_q  <= desc_row;
      qidx_q <= qidx_i;
    end
    rd_idx_q <= addr_q;
    pc_idx_q <= rd_idx_q;
    for (int w = 0; w < DESC_WORDS; w++) begin
      pc_q[w] <= popcnt64(rd_data_q[w] ^ qry_q[w]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      rd_v_q <= 1'b0;
      pc_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.step;
      pc_v_q <= rd_v_q;
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.step) begin
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int w = 0; w < DESC_WORDS; w++) begin
      sum = sum + DISTW'(pc_q[w]);
    end
  end

  // Strict less-than keeps the lowest index on equal distances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (cmd_i.start) begin
      have_q      <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (pc_v_q && (!have_q || (sum < best_dist_q))) begin
      have_q      <= 1'b1;
      best_idx_q  <= pc_idx_q;
      best_dist_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_found_q <= have_q;
      out_qidx_q  <= qidx_q;
      out_idx_q   <= OUT_IDX_W'(best_idx_q);
      out_dist_q  <= OUT_DIST_W'(best_dist_q);
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_found_o = out_found_q;
  assign m_qidx_o  = out_qidx_q;
  assign m_idx_o   = out_idx_q;
  assign m_dist_o  = out_dist_q;

endmodule
